// ===== rtl/core/dtq_pkg.sv =====
// dtq_pkg: shared types and codes of the deadline timer queue
// used by dtq_cell and deadline_timer_queue

package dtq_pkg;

  localparam int TimeW = 64;
  localparam int IdW   = 8;
  localparam int RevW  = 16;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_REQ    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_REQ    = 2'd0,
    RES_EXPIRY = 2'd1,
    RES_CANCEL = 2'd2,
    RES_TIME   = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_STALE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam logic [1:0] REG_PRESCALE = 2'd0;
  localparam logic [1:0] REG_REVISION = 2'd1;

  // operation broadcast to every cell in the same cycle
  typedef struct packed {
    logic             ins;      // insert new entry
    logic             del;      // delete entry matching del_id
    logic             pop;      // remove head
    logic [IdW-1:0]   del_id;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] dl;
  } cell_op_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic             valid;
    logic             gone;     // this cell or one before it matched the delete
    logic             le;       // valid and deadline <= new deadline
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] dl;
  } cell_view_t;

endpackage

// ===== rtl/core/dtq_cell.sv =====
// dtq_cell: one slot of the sorted deadline chain
// depends on dtq_pkg; neighbors pass their view each cycle

module dtq_cell (
  input  logic                clk,
  input  logic                rst,
  input  dtq_pkg::cell_op_t   op,
  input  dtq_pkg::cell_view_t prev,   // cell toward the head
  input  dtq_pkg::cell_view_t next,   // cell toward the tail
  input  logic                first,
  output dtq_pkg::cell_view_t view
);
  import dtq_pkg::*;

  logic             valid;
  logic [IdW-1:0]   id;
  logic [TimeW-1:0] dl;
  logic             match, gone, le;
  logic             p_valid, p_le, p_gone;

  assign p_valid = first ? 1'b1 : prev.valid;
  assign p_le    = first ? 1'b1 : prev.le;
  assign p_gone  = first ? 1'b0 : prev.gone;
  assign match   = op.del && valid && (id == op.del_id);
  assign gone    = p_gone || match;
  assign le      = valid && (dl <= op.dl);

  assign view = '{valid: valid, gone: gone, le: le, id: id, dl: dl};

  // delete and insert are never in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.pop || (op.del && gone)) begin
      valid <= next.valid;
      id    <= next.id;
      dl    <= next.dl;
    end else if (op.ins) begin
      if (!le && p_le && p_valid) begin
        valid <= 1'b1;
        id    <= op.id;
        dl    <= op.dl;
      end else if (!le && !first) begin
        valid <= prev.valid;
        id    <= prev.id;
        dl    <= prev.dl;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (!first && valid) |-> prev.valid)
    else $error("hole in deadline chain");
  assert property (@(posedge clk) disable iff (rst)
    (!first && valid) |-> (prev.dl <= dl))
    else $error("deadline chain out of order");
  assert property (@(posedge clk) disable iff (rst)
    (op.pop && first) |-> valid)
    else $error("pop of empty chain");

endmodule

// ===== rtl/core/deadline_timer_queue.sv =====
// deadline_timer_queue: top level, time counter, request control, cell chain
// depends on dtq_pkg and dtq_cell
//
//  channel  dir  handshake                 payload
//  s_axis   in   s_tvalid / s_tready       kind, request_id, delay, deadline, revision_tag
//  m_axis   out  m_tvalid / m_tready       result_kind, status, result_id, time_value, last
//  apb      in   psel/penable/pwrite/pready prescale_select @0, config_revision @4
//
// requests and cancels: after acceptance, one delete pass over the chain (S_DEL),
// then a decide step (S_DECIDE) that loads the answer; time reads skip the delete pass
// a tick: after acceptance the chain head is checked in S_EXP; each due expiry
// is popped and loaded into the output register, each further one only once the
// output register has emptied (up to 16 per tick); a tick with nothing due gives no result
// one item at a time; the input stalls while a result waits in the output register
// rst is synchronous: chain empty, time and prescale count zero, revision 1

module deadline_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // request_id[7:0], delay[71:8], deadline[135:72], revision_tag[151:136]
  input  logic [151:0] s_tdata,
  input  logic [1:0]   s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,  // status[1:0], result_id[9:2], time_value[73:10]
  output logic [1:0]   m_tuser,  // result_kind
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import dtq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEL   = 5'b00010,
    S_DECIDE= 5'b00100,
    S_EXP   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;

  // configuration
  logic [2:0]  prescale_select;
  logic [15:0] config_revision;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_select <= '0;
      config_revision <= 16'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_REVISION[0]) config_revision <= pwdata[15:0];
      else                             prescale_select <= pwdata[2:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_REVISION[0]) prdata[15:0] = config_revision;
    else                             prdata[2:0]  = prescale_select;
  end

  // captured item
  kind_t        kind;
  logic [7:0]   rid;
  logic [63:0]  dl;
  logic         stale;

  logic [63:0]  current_time;
  logic [7:0]   prescale_count;
  logic [4:0]   exp_cnt;

  // output register
  logic [1:0]  o_kind, o_status;
  logic [7:0]  o_id;
  logic [63:0] o_time;
  logic        o_last;

  cell_op_t   op;
  cell_view_t views [QUEUE_DEPTH];
  logic       found, found_q, full, head_due;

  assign found    = views[QUEUE_DEPTH-1].gone;
  assign full     = views[QUEUE_DEPTH-1].valid;
  assign head_due = views[0].valid && (views[0].dl <= current_time);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      cell_view_t pv, nv;
      if (g == 0) begin : g_h
        assign pv = '0;
      end else begin : g_m
        assign pv = views[g-1];
      end
      if (g == QUEUE_DEPTH-1) begin : g_t
        assign nv = '0;
      end else begin : g_n
        assign nv = views[g+1];
      end
      dtq_cell u_cell (
        .clk(clk), .rst(rst), .op(op), .prev(pv), .next(nv),
        .first(g == 0), .view(views[g])
      );
    end
  endgenerate

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata  = {6'd0, o_time, o_id, o_status};
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;

  logic [8:0] div_m1;
  always_comb begin
    div_m1 = (prescale_select == 3'd7) ? 9'd255 : ((9'd1 << prescale_select) - 9'd1);
  end

  // chain operation for this cycle
  // a stale request leaves any queued entry of its id in place
  always_comb begin
    op = '0;
    op.del_id = rid;
    op.id     = rid;
    op.dl     = dl;
    unique case (state)
      S_DEL:    op.del = (kind == KIND_CANCEL) || !stale;
      S_DECIDE: op.ins = (kind == KIND_REQ) && !stale && (dl > current_time) && !full;
      S_EXP:    op.pop = !m_tvalid && head_due;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      current_time   <= '0;
      prescale_count <= '0;
      exp_cnt        <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          kind  <= kind_t'(s_tuser);
          rid   <= s_tdata[7:0];
          stale <= (s_tdata[151:136] != 16'd0) && (s_tdata[151:136] != config_revision);
          dl    <= (s_tdata[71:8] != 64'd0) ? current_time + s_tdata[71:8]
                                            : s_tdata[135:72];
          exp_cnt <= '0;
          if (kind_t'(s_tuser) == KIND_TICK) begin
            if ({1'b0, prescale_count} >= div_m1) begin
              prescale_count <= '0;
              current_time   <= current_time + 64'd1;
            end else begin
              prescale_count <= prescale_count + 8'd1;
            end
            state <= S_EXP;
          end else if (kind_t'(s_tuser) == KIND_READ) begin
            state <= S_DECIDE;
          end else begin
            state <= S_DEL;
          end
        end
        S_DEL: begin
          // remember whether the delete pass hit a queued entry
          found_q <= found;
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          m_tvalid <= 1'b1;
          o_last   <= 1'b1;
          unique case (kind)
            KIND_REQ: begin
              o_kind <= RES_REQ;
              o_id   <= rid;
              if (stale) begin
                o_status <= ST_STALE; o_time <= '0;
              end else begin
                o_time <= dl;
                if (dl <= current_time) o_status <= ST_MISS;
                else if (full)          o_status <= ST_FULL;
                else                    o_status <= ST_OK;
              end
            end
            KIND_CANCEL: begin
              o_kind   <= RES_CANCEL;
              o_id     <= rid;
              o_time   <= current_time;
              o_status <= found_q ? ST_OK : ST_MISS;
            end
            default: begin
              o_kind   <= RES_TIME;
              o_id     <= '0;
              o_time   <= current_time;
              o_status <= ST_OK;
            end
          endcase
          state <= S_IDLE;
        end
        S_EXP: if (!m_tvalid) begin
          if (head_due && exp_cnt != 5'd16) begin
            m_tvalid <= 1'b1;
            o_kind   <= RES_EXPIRY;
            o_status <= ST_OK;
            o_id     <= views[0].id;
            o_time   <= views[0].dl;
            o_last   <= (exp_cnt == 5'd15) || !(views[1].valid && views[1].dl <= current_time);
            exp_cnt  <= exp_cnt + 5'd1;
            if ((exp_cnt == 5'd15) ||
                !(views[1].valid && views[1].dl <= current_time)) state <= S_IDLE;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    op.pop |-> head_due)
    else $error("pop of entry not yet due");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({op.ins, op.del, op.pop}))
    else $error("conflicting chain operations");

endmodule
